// ----- rtl/core/sdld_pkg.sv -----
// shared constants, types and tables for the distance display block
package sdld_pkg;

  localparam int NumDigits = 4;
  localparam int DigitIdxW = 2;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RX_NUM   = 3'd0,
    CFG_SERIES_R = 3'd1,
    CFG_COEF_A   = 3'd2,
    CFG_COEF_B   = 3'd3,
    CFG_COEF_C   = 3'd4
  } cfg_idx_e;

  localparam logic [31:0] RxNumReset   = 32'd1551515;
  localparam logic [15:0] SeriesReset  = 16'd250;
  localparam logic [31:0] CoefAReset   = 32'd4003339;
  localparam logic [23:0] CoefBReset   = 24'hFF67E9;  // -38935
  localparam logic [31:0] CoefCReset   = 32'd7307264;

  localparam logic [23:0] RxMax   = 24'hFFFF00;
  localparam logic [29:0] DistMax = 30'd655359998;

  // seven-segment pattern, segments a..g in bits 0..6
  function automatic logic [6:0] seg_decode(input logic [3:0] digit);
    logic [6:0] seg;
    unique case (digit)
      4'd0: seg = 7'h3F;
      4'd1: seg = 7'h06;
      4'd2: seg = 7'h5B;
      4'd3: seg = 7'h4F;
      4'd4: seg = 7'h66;
      4'd5: seg = 7'h6D;
      4'd6: seg = 7'h7D;
      4'd7: seg = 7'h07;
      4'd8: seg = 7'h7F;
      4'd9: seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// ----- rtl/core/sensor_distance_led_display.sv -----
// top level: sample to distance conversion and multiplexed digit display
// A tick request returns one digit's segment pattern and one-hot select in the
// output register in the next cycle; the output register frees the input side so
// a tick is taken every cycle while idle and not stalled, even while the last
// result is still being drained. A sample request produces no result and keeps
// the block busy (a zero sample skips the divider and the subtraction) through a
// 40-step bit-serial restoring divider, a subtract and clamp for the resistance,
// two shift-add multiplies for the quadratic, an add of the constant, the signed
// linear term and clamp, and a sequencer that emits one decimal digit per cycle
// (integer digits ones first by reciprocal multiply, then a switch-over step,
// fraction digits by times ten).
module sensor_distance_led_display (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic                          action_i,
  input  logic [11:0]                   adc_sample_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [7:0]                    segments_lit_o,
  output logic [3:0]                    digit_select_o,
  input  logic                          cfg_we_i,
  input  logic [sdld_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sdld_pkg::CfgDataW-1:0] cfg_data_i
);
  import sdld_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_RX, ST_MULA, ST_MULB, ST_SUM, ST_CLAMP,
    ST_INT, ST_FRAC
  } state_e;

  // configuration registers
  logic [31:0] rx_num_q, coef_a_q, coef_c_q;
  logic [15:0] series_q;
  logic [23:0] coef_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_num_q <= RxNumReset;
      series_q <= SeriesReset;
      coef_a_q <= CoefAReset;
      coef_b_q <= CoefBReset;
      coef_c_q <= CoefCReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RX_NUM:   rx_num_q <= cfg_data_i;
        CFG_SERIES_R: series_q <= cfg_data_i[15:0];
        CFG_COEF_A:   coef_a_q <= cfg_data_i;
        CFG_COEF_B:   coef_b_q <= cfg_data_i[23:0];
        CFG_COEF_C:   coef_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e          state_q;
  logic [5:0]      cnt_q;
  logic [39:0]     quo_q;     // dividend shifts out, quotient shifts in
  logic [12:0]     rem_q;
  logic [11:0]     den_q;
  logic [23:0]     rx_q;
  logic [63:0]     acc_q;     // shift-add accumulator
  logic [31:0]     mpl_q;     // multiplier bits, lsb first
  logic [63:0]     mcd_q;     // shifted multiplicand
  logic [63:0]     qarx_q;
  logic [13:0]     ip_q;
  logic [15:0]     frac_q;
  logic [3:0]      dig_q [NumDigits];
  logic [DigitIdxW-1:0] pos_q, point_q, scan_q;
  logic            out_valid_q;
  logic [7:0]      seg_q;
  logic [3:0]      sel_q;

  logic in_acc, out_free;
  assign out_free = !out_valid_q || !stall_i;
  assign stall_o  = (state_q != ST_IDLE) || !out_free;
  assign in_acc   = valid_i && !stall_o;

  // divider step
  logic [12:0] rem_sh;
  logic [13:0] rem_try;
  assign rem_sh  = {rem_q[11:0], quo_q[39]};
  assign rem_try = {1'b0, rem_sh} - {2'b0, den_q};

  // rx after subtraction and clamp
  logic [40:0] rx_diff;
  assign rx_diff = {1'b0, quo_q} - {17'b0, series_q, 8'b0};

  // signed linear term and total
  logic signed [48:0] lin;
  logic signed [65:0] total;
  assign lin   = $signed(coef_b_q) * $signed({1'b0, rx_q});
  assign total = $signed({2'b0, qarx_q}) + $signed({{17{lin[48]}}, lin});

  // distance clamped to the display range
  logic [29:0] dist_c;
  always_comb begin
    if (total[65])                       dist_c = '0;
    else if (total[65:8] > 58'(DistMax)) dist_c = DistMax;
    else                                 dist_c = total[37:8];
  end

  // times ten for the next fraction digit
  logic [19:0] frac10;
  assign frac10 = {1'b0, frac_q, 3'b0} + {3'b0, frac_q, 1'b0};

  // ones digit by reciprocal multiply, exact for ip below 10000
  logic [26:0] ip_mul;
  logic [10:0] ip_div10;
  logic [13:0] ip_tens;
  logic [13:0] ip_mod10;
  assign ip_mul   = ip_q * 13'd6554;
  assign ip_div10 = ip_mul[26:16];
  assign ip_tens  = {ip_div10, 3'b0} + {2'b0, ip_div10, 1'b0};
  assign ip_mod10 = ip_q - ip_tens;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      point_q     <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      den_q       <= '0;
      rx_q        <= '0;
      acc_q       <= '0;
      mpl_q       <= '0;
      mcd_q       <= '0;
      qarx_q      <= '0;
      ip_q        <= '0;
      frac_q      <= '0;
      seg_q       <= '0;
      sel_q       <= '0;
      for (int k = 0; k < NumDigits; k++) dig_q[k] <= 4'd0;
    end else begin
      // result register: load on a tick, clear once drained
      if (in_acc && action_i) out_valid_q <= 1'b1;
      else if (!stall_i)      out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (action_i) begin
              seg_q <= {scan_q == point_q, seg_decode(dig_q[scan_q])};
              sel_q <= 4'(1) << scan_q;
              scan_q <= (scan_q == DigitIdxW'(NumDigits - 1)) ? '0 : scan_q + 1'b1;
            end else if (adc_sample_i == 12'd0) begin
              rx_q    <= RxMax;
              state_q <= ST_MULA;
              cnt_q   <= '0;
            end else begin
              quo_q   <= {rx_num_q, 8'b0};
              rem_q   <= '0;
              den_q   <= adc_sample_i;
              cnt_q   <= '0;
              state_q <= ST_DIV;
            end
            acc_q <= '0;
            mcd_q <= '0;
          end
        end
        ST_DIV: begin
          if (!rem_try[13]) begin
            rem_q <= rem_try[12:0];
            quo_q <= {quo_q[38:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[38:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd39) state_q <= ST_RX;
        end
        ST_RX: begin
          if (rx_diff[40])                 rx_q <= '0;
          else if (rx_diff[39:0] > 40'(RxMax)) rx_q <= RxMax;
          else                             rx_q <= rx_diff[23:0];
          state_q <= ST_MULA;
          cnt_q   <= '0;
        end
        ST_MULA: begin
          // coef_a * rx, shift-add over coef_a bits
          if (cnt_q == 6'd0) begin
            mpl_q <= coef_a_q;
            mcd_q <= {40'b0, rx_q};
            acc_q <= '0;
            cnt_q <= 6'd1;
          end else begin
            if (mpl_q[0]) acc_q <= acc_q + mcd_q;
            mpl_q <= mpl_q >> 1;
            mcd_q <= mcd_q << 1;
            if (cnt_q == 6'd32) begin
              state_q <= ST_MULB;
              cnt_q   <= '0;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_MULB: begin
          // qa * rx
          if (cnt_q == 6'd0) begin
            mpl_q <= acc_q[55:24];
            mcd_q <= {40'b0, rx_q};
            acc_q <= '0;
            cnt_q <= 6'd1;
          end else begin
            if (mpl_q[0]) acc_q <= acc_q + mcd_q;
            mpl_q <= mpl_q >> 1;
            mcd_q <= mcd_q << 1;
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == 6'd32) state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          qarx_q  <= acc_q + {24'b0, coef_c_q, 8'b0};
          state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          ip_q    <= dist_c[29:16];
          frac_q  <= dist_c[15:0];
          state_q <= ST_INT;
          pos_q   <= '0;
        end
        ST_INT: begin
          // one integer digit per cycle, ones first
          if (ip_q == 14'd0) begin
            state_q <= ST_FRAC;
          end else begin
            dig_q[pos_q] <= ip_mod10[3:0];
            point_q <= pos_q;
            ip_q    <= {3'b0, ip_div10};
            if (pos_q == DigitIdxW'(NumDigits - 1)) state_q <= ST_IDLE;
            else pos_q <= pos_q + 1'b1;
          end
        end
        ST_FRAC: begin
          dig_q[pos_q] <= frac10[19:16];
          frac_q <= frac10[15:0];
          if (pos_q == DigitIdxW'(NumDigits - 1)) state_q <= ST_IDLE;
          else pos_q <= pos_q + 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign valid_o        = out_valid_q;
  assign segments_lit_o = seg_q;
  assign digit_select_o = sel_q;

`ifndef SYNTH
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $onehot(digit_select_o)) else $error("digit select not one-hot");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> stall_o) else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o && $stable(segments_lit_o))
    else $error("stalled result changed");
`endif

endmodule
